// ===== rtl/tcpq_pkg.sv =====
package tcpq_pkg;

   localparam int DEPTH       = 64;
   localparam int NUM_CLASSES = 3;
   localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int SUM_W       = CNT_W + 2;
   localparam int ADDR_W      = $clog2(NUM_CLASSES * DEPTH);
   localparam int ID_W        = 16;
   localparam int CLS_W       = 2;
   localparam int STATUS_W    = 3;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_SERVE   = 1'b1;

   localparam logic [CLS_W-1:0] CLS_GENERAL = 2'd0;
   localparam logic [CLS_W-1:0] CLS_SENIOR  = 2'd1;
   localparam logic [CLS_W-1:0] CLS_VIP     = 2'd2;
   localparam logic [CLS_W-1:0] CLS_INVALID = 2'd3;

   typedef enum logic [STATUS_W-1:0] {
      ST_ENQUEUED = 3'd0,
      ST_SERVED   = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_FULL     = 3'd3,
      ST_INVALID  = 3'd4
   } status_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] addr;
      status_type        status;
      logic [CLS_W-1:0]  cls;
   } cmd_type;

   typedef struct packed {
      logic [SUM_W-1:0] total;
      logic [SUM_W-1:0] occ_sum;
   } fill_type;

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLS_W-1:0] c,
                                                   input logic [PTR_W-1:0] p);
      slot_addr = ADDR_W'(c) * ADDR_W'(DEPTH) + ADDR_W'(p);
   endfunction

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

endpackage

// ===== rtl/tcpq_sched.sv =====
module tcpq_sched (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_fire,
   input  logic                      op,
   input  logic [1:0]                priority_class,
   output tcpq_pkg::cmd_type         cmd,
   output tcpq_pkg::fill_type        fill
);
   import tcpq_pkg::*;

   logic [PTR_W-1:0] head_ff [NUM_CLASSES];
   logic [PTR_W-1:0] head_in [NUM_CLASSES];
   logic [PTR_W-1:0] tail_ff [NUM_CLASSES];
   logic [PTR_W-1:0] tail_in [NUM_CLASSES];
   logic [CNT_W-1:0] occ_ff  [NUM_CLASSES];
   logic [CNT_W-1:0] occ_in  [NUM_CLASSES];
   logic [CNT_W-1:0] total_ff;
   logic [CNT_W-1:0] total_in;
   logic [CLS_W-1:0] pick;
   logic             any;

   always_comb begin
      any  = 1'b1;
      pick = CLS_VIP;
      priority if (occ_ff[2] != '0) begin
         pick = CLS_VIP;
      end else if (occ_ff[1] != '0) begin
         pick = CLS_SENIOR;
      end else if (occ_ff[0] != '0) begin
         pick = CLS_GENERAL;
      end else begin
         any = 1'b0;
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      occ_in   = occ_ff;
      total_in = total_ff;
      cmd      = '{wr_en: 1'b0, addr: '0, status: ST_EMPTY, cls: '0};
      unique case (op)
         OP_ENQUEUE: begin
            priority if (priority_class == CLS_INVALID) begin
               cmd.status = ST_INVALID;
            end else if (total_ff >= CNT_W'(DEPTH)) begin
               cmd.status = ST_FULL;
            end else begin
               cmd.status              = ST_ENQUEUED;
               cmd.wr_en               = 1'b1;
               cmd.addr                = slot_addr(priority_class,
                                                   tail_ff[priority_class]);
               tail_in[priority_class] = next_ptr(tail_ff[priority_class]);
               occ_in[priority_class]  = occ_ff[priority_class] + CNT_W'(1);
               total_in                = total_ff + CNT_W'(1);
            end
         end
         OP_SERVE: begin
            if (any) begin
               cmd.status    = ST_SERVED;
               cmd.cls       = pick;
               cmd.addr      = slot_addr(pick, head_ff[pick]);
               head_in[pick] = next_ptr(head_ff[pick]);
               occ_in[pick]  = occ_ff[pick] - CNT_W'(1);
               total_in      = total_ff - CNT_W'(1);
            end
         end
         default: begin
            cmd.status = ST_EMPTY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            occ_ff[i]  <= '0;
         end
         total_ff <= '0;
      end else if (req_fire) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         occ_ff   <= occ_in;
         total_ff <= total_in;
      end
   end

   assign fill.total   = SUM_W'(total_ff);
   assign fill.occ_sum = SUM_W'(occ_ff[0]) + SUM_W'(occ_ff[1]) + SUM_W'(occ_ff[2]);

endmodule

// ===== rtl/three_class_priority_queue.sv =====
// Three-class strict priority queue (general, senior, VIP).
// Request channel (req_*): req_op 0 enqueues req_passenger_id into the FIFO
// of req_priority_class; req_op 1 serves the oldest entry of the highest
// non-empty class. The three classes share a pool of DEPTH entries, held in
// one single-port-write, one-read identifier memory of 3*DEPTH words.
// Response channel (rsp_*): exactly one item per request, carrying
// rsp_status (enqueued, served, empty, full, invalid class) and, when
// served, the identifier and its class; both are zero otherwise.
// Latency: the response is valid in the cycle after the request is taken.
// Throughput: one request per cycle; the pointer and count update and the
// memory access of a request all happen at its accepting edge, and the
// memory read data register doubles as the response register.
// Stall: while a response waits on rsp_ready low, req_ready is low; it rises
// again in the cycle the response is taken, so no bubble is inserted.
// Reset: clears all pointers and counts; the queue is empty and no response
// is pending. Memory contents are not cleared and need not be.
module three_class_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [15:0] req_passenger_id,
   input  logic [1:0]  req_priority_class,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_served_id,
   output logic [1:0]  rsp_served_class
);
   import tcpq_pkg::*;

   logic              req_fire;
   cmd_type           cmd;
   fill_type          fill;
   logic [ID_W-1:0]   id_mem [NUM_CLASSES * DEPTH];
   logic [ID_W-1:0]   rd_data_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   status_type        status_ff;
   logic [CLS_W-1:0]  class_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   tcpq_sched u_sched (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .op             (req_op),
      .priority_class (req_priority_class),
      .cmd            (cmd),
      .fill           (fill)
   );

   always_ff @(posedge clock) begin
      if (req_fire && cmd.wr_en) begin
         id_mem[cmd.addr] <= req_passenger_id;
      end
      if (req_fire) begin
         rd_data_ff <= id_mem[cmd.addr];
         status_ff  <= cmd.status;
         class_ff   <= cmd.cls;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_served_id    = (status_ff == ST_SERVED) ? rd_data_ff : '0;
   assign rsp_served_class = (status_ff == ST_SERVED) ? class_ff : '0;

   assert property (@(posedge clock) disable iff (reset)
      fill.total <= SUM_W'(DEPTH))
      else $error("pool occupancy exceeds depth");

   assert property (@(posedge clock) disable iff (reset)
      fill.occ_sum == fill.total)
      else $error("class occupancies disagree with pool occupancy");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_op == OP_ENQUEUE && req_priority_class != CLS_INVALID
      && fill.total < SUM_W'(DEPTH)
      |=> fill.total == $past(fill.total) + SUM_W'(1) && rsp_status == ST_ENQUEUED)
      else $error("accepted enqueue not counted");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_op == OP_SERVE && fill.total == '0
      |=> rsp_status == ST_EMPTY && fill.total == '0)
      else $error("serve on empty pool not reported as empty");

endmodule

// ===== dv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tcpq_pkg::*;

   typedef struct {
      logic             op;
      logic [ID_W-1:0]  pid;
      logic [CLS_W-1:0] cls;
      int unsigned      gap;
      bit               drain_first;
   } req_item_type;

   typedef struct {
      status_type       status;
      logic [ID_W-1:0]  sid;
      logic [CLS_W-1:0] scls;
   } reply_item_type;

   localparam int HOLD_AT     = 400;
   localparam int HOLD_CYCLES = 250;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_op = OP_ENQUEUE;
   logic [ID_W-1:0]  req_passenger_id = '0;
   logic [CLS_W-1:0] req_priority_class = CLS_GENERAL;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [2:0]       rsp_status;
   logic [ID_W-1:0]  rsp_served_id;
   logic [CLS_W-1:0] rsp_served_class;

   req_item_type    pending_items[$];
   reply_item_type  awaited_replies[$];
   logic [ID_W-1:0] waiting_ids[NUM_CLASSES][$];
   int          pool_count = 0;
   int          taken_count = 0;
   int          reply_count = 0;
   int          fail_count = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   bit          sender_lazy = 1'b0;
   bit          rsp_lazy = 1'b0;

   three_class_priority_queue dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_passenger_id   (req_passenger_id),
      .req_priority_class (req_priority_class),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_served_id      (rsp_served_id),
      .rsp_served_class   (rsp_served_class)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void book_request(input req_item_type it);
      reply_item_type exp;
      int             pick;
      exp = '{status: ST_ENQUEUED, sid: '0, scls: CLS_GENERAL};
      pick = -1;
      if (it.op == OP_ENQUEUE) begin
         if (it.cls == CLS_INVALID) begin
            exp.status = ST_INVALID;
         end else if (pool_count == DEPTH) begin
            exp.status = ST_FULL;
         end else begin
            waiting_ids[it.cls].push_back(it.pid);
            pool_count++;
         end
      end else begin
         for (int c = NUM_CLASSES - 1; c >= 0 && pick < 0; c--)
            if (waiting_ids[c].size() != 0) pick = c;
         if (pick < 0) begin
            exp.status = ST_EMPTY;
         end else begin
            exp.status = ST_SERVED;
            exp.sid    = waiting_ids[pick].pop_front();
            exp.scls   = CLS_W'(pick);
            pool_count--;
         end
      end
      awaited_replies.push_back(exp);
   endfunction

   task automatic queue_request(input logic op, input logic [ID_W-1:0] pid,
                                input logic [CLS_W-1:0] cls, input bit drain_first);
      req_item_type it;
      it.op          = op;
      it.pid         = pid;
      it.cls         = cls;
      it.gap         = sender_lazy ? $urandom_range(0, 19) : 0;
      it.drain_first = drain_first;
      pending_items.push_back(it);
   endtask

   // driver: stage the next item, wait out its gap, hold it until taken
   req_item_type offered;
   bit           have_next = 1'b0;
   int unsigned  gap_left = 0;

   always @(posedge clock) begin
      logic show;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            book_request(offered);
            taken_count <= taken_count + 1;
            show = 1'b0;
         end else begin
            show = req_valid;
         end
         if (!show) begin
            if (!have_next && pending_items.size() != 0 &&
                !(pending_items[0].drain_first && awaited_replies.size() != 0)) begin
               offered   = pending_items.pop_front();
               have_next = 1'b1;
               gap_left  = offered.gap;
            end
            if (have_next) begin
               if (gap_left == 0) begin
                  show      = 1'b1;
                  have_next = 1'b0;
               end else begin
                  gap_left--;
               end
            end
         end
         req_valid <= show;
         if (show) begin
            req_op             <= offered.op;
            req_passenger_id   <= offered.pid;
            req_priority_class <= offered.cls;
         end
      end
   end

   // long receiver hold-off once, to back up the block
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && taken_count >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // monitor: check each item against the oldest expectation
   int unsigned rsp_stall = 0;

   always @(posedge clock) begin
      reply_item_type exp;
      int unsigned    next_stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         next_stall = rsp_stall;
         if (rsp_valid && rsp_ready) begin
            if (awaited_replies.size() == 0) begin
               $error("unexpected item: status %0d", rsp_status);
               fail_count++;
            end else begin
               exp = awaited_replies.pop_front();
               if (rsp_status !== exp.status) begin
                  $error("status: expected %0d, got %0d", exp.status, rsp_status);
                  fail_count++;
               end
               if (rsp_served_id !== exp.sid) begin
                  $error("served_id: expected %0h, got %0h", exp.sid, rsp_served_id);
                  fail_count++;
               end
               if (rsp_served_class !== exp.scls) begin
                  $error("served_class: expected %0d, got %0d", exp.scls, rsp_served_class);
                  fail_count++;
               end
            end
            reply_count++;
            if (reply_count % 50 == 0) rsp_lazy = ($urandom_range(0, 2) != 0);
            next_stall = rsp_lazy ? $urandom_range(0, 19) : 0;
         end else if (next_stall != 0) begin
            next_stall--;
         end
         rsp_stall <= next_stall;
         rsp_ready <= (next_stall == 0) && (hold_left == 0);
      end
   end

   initial begin
      int phase;
      int kind;
      int len;
      int total;
      logic op;
      logic [CLS_W-1:0] cls;

      queue_request(OP_SERVE,   16'h0000, CLS_GENERAL, 1'b0);
      queue_request(OP_ENQUEUE, 16'hFFFF, CLS_INVALID, 1'b0);
      queue_request(OP_ENQUEUE, 16'h0000, CLS_GENERAL, 1'b0);
      queue_request(OP_ENQUEUE, 16'hFFFF, CLS_SENIOR,  1'b0);
      queue_request(OP_ENQUEUE, 16'h8000, CLS_VIP,     1'b0);
      queue_request(OP_ENQUEUE, 16'h0001, CLS_INVALID, 1'b0);
      queue_request(OP_SERVE,   16'hFFFF, CLS_INVALID, 1'b0);
      queue_request(OP_SERVE,   16'h0000, CLS_GENERAL, 1'b0);
      queue_request(OP_SERVE,   16'h1234, CLS_VIP,     1'b0);
      queue_request(OP_SERVE,   16'h0000, CLS_SENIOR,  1'b0);
      queue_request(OP_ENQUEUE, 16'h0001, CLS_GENERAL, 1'b0);
      queue_request(OP_ENQUEUE, 16'hFFFE, CLS_GENERAL, 1'b0);
      queue_request(OP_ENQUEUE, 16'h1234, CLS_VIP,     1'b0);
      queue_request(OP_ENQUEUE, 16'hAAAA, CLS_SENIOR,  1'b0);
      queue_request(OP_ENQUEUE, 16'h5555, CLS_GENERAL, 1'b0);
      queue_request(OP_ENQUEUE, 16'h7FFF, CLS_VIP,     1'b0);
      for (int i = 0; i < 7; i++)
         queue_request(OP_SERVE, 16'($urandom), CLS_GENERAL, 1'b0);

      // random phases: fill to full, drain to empty, or mixed traffic
      total = pending_items.size();
      phase = 0;
      while (total < 800) begin
         kind        = $urandom_range(0, 2);
         len         = (kind == 0) ? $urandom_range(80, 110) :
                       (kind == 1) ? $urandom_range(50, 80) : $urandom_range(30, 60);
         sender_lazy = ($urandom_range(0, 2) != 0);
         for (int i = 0; i < len; i++) begin
            case (kind)
               0: op = ($urandom_range(0, 9) == 0) ? OP_SERVE : OP_ENQUEUE;
               1: op = ($urandom_range(0, 6) == 0) ? OP_ENQUEUE : OP_SERVE;
               default: op = $urandom_range(0, 1) ? OP_SERVE : OP_ENQUEUE;
            endcase
            if (op == OP_ENQUEUE && $urandom_range(0, 15) != 0)
               cls = CLS_W'($urandom_range(0, 2));
            else
               cls = CLS_W'($urandom_range(0, 3));
            queue_request(op, 16'($urandom), cls,
                          i == 0 && (phase == 2 || $urandom_range(0, 2) == 0));
         end
         total += len;
         phase++;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || have_next || req_valid ||
             awaited_replies.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (fail_count == 0 && awaited_replies.size() == 0)
         $display("PASS three_class_priority_queue");
      else
         $display("FAIL three_class_priority_queue");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL three_class_priority_queue");
      $finish;
   end

endmodule
